/* hw/rtl/cll_pkg.sv */
// Shared types and constants for the configuration text lexer.
`timescale 1ns / 1ps

package cll_pkg;

	localparam int MAX_RES = 3;
	localparam int QDEPTH  = 4;

	localparam logic [15:0] LINE_SAT = 16'hFFFF;
	localparam logic [2:0]  LIT_SAT  = 3'd5;
	localparam logic [2:0]  LIT_MAX  = 3'd4;

	typedef enum logic [3:0] {
		M_IDLE   = 4'd0,
		M_SLASH  = 4'd1,
		M_LCOMM  = 4'd2,
		M_BCOMM  = 4'd3,
		M_BSTAR  = 4'd4,
		M_LT     = 4'd5,
		M_ZERO   = 4'd6,
		M_DEC    = 4'd7,
		M_HEX    = 4'd8,
		M_IDENT  = 4'd9,
		M_STR    = 4'd10,
		M_STRESC = 4'd11,
		M_LIT    = 4'd12
	} mode_t;

	typedef enum logic [3:0] {
		K_NONE   = 4'd0,
		K_IDENT  = 4'd1,
		K_LPAREN = 4'd2,
		K_RPAREN = 4'd3,
		K_NUMBER = 4'd4,
		K_STRING = 4'd5,
		K_EQUAL  = 4'd6,
		K_SEMI   = 4'd7,
		K_LBRACE = 4'd8,
		K_RBRACE = 4'd9,
		K_RANGLE = 4'd10,
		K_OR     = 4'd11,
		K_LSHIFT = 4'd12,
		K_COMMA  = 4'd13,
		K_LE     = 4'd14,
		K_EOF    = 4'd15
	} kind_t;

	typedef enum logic [2:0] {
		E_OK         = 3'd0,
		E_UNFIN_STR  = 3'd1,
		E_BAD_ESC    = 3'd2,
		E_UNTERM_LIT = 3'd3,
		E_LIT_LEN    = 3'd4,
		E_OPEN_COMM  = 3'd5,
		E_UNEXPECTED = 3'd6
	} err_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] value;
		logic        char_valid;
		logic        token_end;
		logic [15:0] line_no;
		err_t        err;
	} res_t;

	typedef struct packed {
		logic [1:0]                n;
		res_t [MAX_RES-1:0]        r;
	} batch_t;

endpackage

/* hw/rtl/cll_lexer.sv */
// Lexer state registers and the per-byte transition and token logic.
`timescale 1ns / 1ps

module cll_lexer (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            take,
	input  logic [7:0]      c,
	input  logic            last,
	output cll_pkg::batch_t batch
);
	import cll_pkg::*;

	mode_t       mode_q, mode_d;
	logic [31:0] acc_q, acc_d;
	logic [2:0]  lcnt_q, lcnt_d;
	logic [15:0] lc_q, lc_d;
	logic [15:0] tl_q, tl_d;
	logic        halt_q, halt_d;
	logic [15:0] pre;
	logic        restart;
	logic        hex_ok;
	logic [3:0]  hex_v;

	function automatic res_t mk(kind_t k, logic [31:0] v, logic cv, logic e,
			logic [15:0] ln, err_t er);
		res_t r;
		r.kind       = k;
		r.value      = v;
		r.char_valid = cv;
		r.token_end  = e;
		r.line_no    = ln;
		r.err        = er;
		return r;
	endfunction

	always_comb begin
		hex_ok = 1'b1;
		hex_v  = c[3:0];
		if (c inside {["0":"9"]}) begin
			hex_v = c[3:0];
		end else if (c inside {["a":"f"], ["A":"F"]}) begin
			hex_v = c[3:0] + 4'd9;
		end else begin
			hex_ok = 1'b0;
		end
	end

	always_comb begin
		mode_d  = mode_q;
		acc_d   = acc_q;
		lcnt_d  = lcnt_q;
		lc_d    = lc_q;
		tl_d    = tl_q;
		halt_d  = halt_q;
		batch   = '0;
		restart = 1'b0;
		pre     = lc_q;
		if (take && !halt_q) begin
			case (mode_q)
				M_LCOMM: begin
					if (c == 8'h0A) mode_d = M_IDLE;
				end
				M_BCOMM: begin
					if (c == "*") mode_d = M_BSTAR;
				end
				M_BSTAR: begin
					if (c == "/") mode_d = M_IDLE;
					else if (c != "*") mode_d = M_BCOMM;
				end
				M_SLASH: begin
					if (c == "/") begin
						mode_d = M_LCOMM;
					end else if (c == "*") begin
						mode_d = M_BCOMM;
					end else begin
						batch.r[batch.n] = mk(K_NONE, '0, 1'b0, 1'b1, tl_q, E_UNEXPECTED);
						batch.n = batch.n + 2'd1;
						halt_d = 1'b1;
						mode_d = M_IDLE;
					end
				end
				M_LT: begin
					if (c == "<") begin
						batch.r[batch.n] = mk(K_LSHIFT, '0, 1'b0, 1'b1, tl_q, E_OK);
						batch.n = batch.n + 2'd1;
						mode_d = M_IDLE;
					end else if (c == "=") begin
						batch.r[batch.n] = mk(K_LE, '0, 1'b0, 1'b1, tl_q, E_OK);
						batch.n = batch.n + 2'd1;
						mode_d = M_IDLE;
					end else begin
						batch.r[batch.n] = mk(K_NONE, '0, 1'b0, 1'b1, tl_q, E_UNEXPECTED);
						batch.n = batch.n + 2'd1;
						halt_d = 1'b1;
						mode_d = M_IDLE;
					end
				end
				M_STR: begin
					if (c == "\"") begin
						batch.r[batch.n] = mk(K_STRING, '0, 1'b0, 1'b1, tl_q, E_OK);
						batch.n = batch.n + 2'd1;
						mode_d = M_IDLE;
					end else if (c == "\\") begin
						mode_d = M_STRESC;
					end else begin
						batch.r[batch.n] = mk(K_STRING, {24'd0, c}, 1'b1, 1'b0, tl_q, E_OK);
						batch.n = batch.n + 2'd1;
					end
				end
				M_STRESC: begin
					if (c == "\\" || c == "'" || c == "\"") begin
						batch.r[batch.n] = mk(K_STRING, {24'd0, c}, 1'b1, 1'b0, tl_q, E_OK);
						batch.n = batch.n + 2'd1;
						mode_d = M_STR;
					end else begin
						batch.r[batch.n] = mk(K_NONE, '0, 1'b0, 1'b1, lc_q, E_BAD_ESC);
						batch.n = batch.n + 2'd1;
						halt_d = 1'b1;
						mode_d = M_IDLE;
					end
				end
				M_LIT: begin
					if (c == "'") begin
						if (lcnt_q == 3'd0 || lcnt_q > LIT_MAX) begin
							batch.r[batch.n] = mk(K_NONE, '0, 1'b0, 1'b1, lc_q, E_LIT_LEN);
							batch.n = batch.n + 2'd1;
							halt_d = 1'b1;
						end else begin
							batch.r[batch.n] = mk(K_NUMBER, acc_q, 1'b0, 1'b1, tl_q, E_OK);
							batch.n = batch.n + 2'd1;
						end
						mode_d = M_IDLE;
					end else begin
						acc_d = {acc_q[23:0], c};
						if (lcnt_q != LIT_SAT) lcnt_d = lcnt_q + 3'd1;
					end
				end
				M_ZERO: begin
					if (c == "x") begin
						mode_d = M_HEX;
						acc_d  = '0;
					end else if (c inside {["0":"9"]}) begin
						mode_d = M_DEC;
						acc_d  = {28'd0, c[3:0]};
					end else begin
						batch.r[batch.n] = mk(K_NUMBER, '0, 1'b0, 1'b1, tl_q, E_OK);
						batch.n = batch.n + 2'd1;
						restart = 1'b1;
					end
				end
				M_DEC: begin
					if (c inside {["0":"9"]}) begin
						acc_d = (acc_q << 3) + (acc_q << 1) + {28'd0, c[3:0]};
					end else begin
						batch.r[batch.n] = mk(K_NUMBER, acc_q, 1'b0, 1'b1, tl_q, E_OK);
						batch.n = batch.n + 2'd1;
						restart = 1'b1;
					end
				end
				M_HEX: begin
					if (hex_ok) begin
						acc_d = {acc_q[27:0], hex_v};
					end else begin
						batch.r[batch.n] = mk(K_NUMBER, acc_q, 1'b0, 1'b1, tl_q, E_OK);
						batch.n = batch.n + 2'd1;
						restart = 1'b1;
					end
				end
				M_IDENT: begin
					if (c inside {["a":"z"], ["A":"Z"], ["0":"9"], "_"}) begin
						batch.r[batch.n] = mk(K_IDENT, acc_q, 1'b1, 1'b0, tl_q, E_OK);
						batch.n = batch.n + 2'd1;
						acc_d = {24'd0, c};
					end else begin
						batch.r[batch.n] = mk(K_IDENT, acc_q, 1'b1, 1'b1, tl_q, E_OK);
						batch.n = batch.n + 2'd1;
						restart = 1'b1;
					end
				end
				default: begin
					restart = 1'b1;
				end
			endcase

			if (restart) begin
				mode_d = M_IDLE;
				tl_d   = lc_q;
				case (c)
					" ", 8'h09, 8'h0A, 8'h0D: begin
					end
					"(": begin
						batch.r[batch.n] = mk(K_LPAREN, '0, 1'b0, 1'b1, lc_q, E_OK);
						batch.n = batch.n + 2'd1;
					end
					")": begin
						batch.r[batch.n] = mk(K_RPAREN, '0, 1'b0, 1'b1, lc_q, E_OK);
						batch.n = batch.n + 2'd1;
					end
					"{": begin
						batch.r[batch.n] = mk(K_LBRACE, '0, 1'b0, 1'b1, lc_q, E_OK);
						batch.n = batch.n + 2'd1;
					end
					"}": begin
						batch.r[batch.n] = mk(K_RBRACE, '0, 1'b0, 1'b1, lc_q, E_OK);
						batch.n = batch.n + 2'd1;
					end
					">": begin
						batch.r[batch.n] = mk(K_RANGLE, '0, 1'b0, 1'b1, lc_q, E_OK);
						batch.n = batch.n + 2'd1;
					end
					"=": begin
						batch.r[batch.n] = mk(K_EQUAL, '0, 1'b0, 1'b1, lc_q, E_OK);
						batch.n = batch.n + 2'd1;
					end
					";": begin
						batch.r[batch.n] = mk(K_SEMI, '0, 1'b0, 1'b1, lc_q, E_OK);
						batch.n = batch.n + 2'd1;
					end
					",": begin
						batch.r[batch.n] = mk(K_COMMA, '0, 1'b0, 1'b1, lc_q, E_OK);
						batch.n = batch.n + 2'd1;
					end
					"|": begin
						batch.r[batch.n] = mk(K_OR, '0, 1'b0, 1'b1, lc_q, E_OK);
						batch.n = batch.n + 2'd1;
					end
					"/": mode_d = M_SLASH;
					"<": mode_d = M_LT;
					"\"": mode_d = M_STR;
					"'": begin
						mode_d = M_LIT;
						acc_d  = '0;
						lcnt_d = '0;
					end
					default: begin
						if (c == "0") begin
							mode_d = M_ZERO;
							acc_d  = '0;
						end else if (c inside {["1":"9"]}) begin
							mode_d = M_DEC;
							acc_d  = {28'd0, c[3:0]};
						end else if (c inside {["a":"z"], ["A":"Z"], "_"}) begin
							mode_d = M_IDENT;
							acc_d  = {24'd0, c};
						end else begin
							batch.r[batch.n] = mk(K_NONE, '0, 1'b0, 1'b1, lc_q, E_UNEXPECTED);
							batch.n = batch.n + 2'd1;
							halt_d = 1'b1;
						end
					end
				endcase
			end

			if (c == 8'h0A && lc_q != LINE_SAT) lc_d = lc_q + 16'd1;

			if (last && !halt_d) begin
				case (mode_d)
					M_SLASH, M_LT: begin
						batch.r[batch.n] = mk(K_NONE, '0, 1'b0, 1'b1, tl_d, E_UNEXPECTED);
						batch.n = batch.n + 2'd1;
						halt_d = 1'b1;
					end
					M_BCOMM, M_BSTAR: begin
						batch.r[batch.n] = mk(K_NONE, '0, 1'b0, 1'b1, pre, E_OPEN_COMM);
						batch.n = batch.n + 2'd1;
						halt_d = 1'b1;
					end
					M_STR, M_STRESC: begin
						batch.r[batch.n] = mk(K_NONE, '0, 1'b0, 1'b1, lc_d, E_UNFIN_STR);
						batch.n = batch.n + 2'd1;
						halt_d = 1'b1;
					end
					M_LIT: begin
						batch.r[batch.n] = mk(K_NONE, '0, 1'b0, 1'b1, lc_d, E_UNTERM_LIT);
						batch.n = batch.n + 2'd1;
						halt_d = 1'b1;
					end
					M_ZERO, M_DEC, M_HEX: begin
						batch.r[batch.n] = mk(K_NUMBER, acc_d, 1'b0, 1'b1, tl_d, E_OK);
						batch.n = batch.n + 2'd1;
					end
					M_IDENT: begin
						batch.r[batch.n] = mk(K_IDENT, acc_d, 1'b1, 1'b1, tl_d, E_OK);
						batch.n = batch.n + 2'd1;
					end
					default: begin
					end
				endcase
				if (!halt_d) begin
					batch.r[batch.n] = mk(K_EOF, '0, 1'b0, 1'b1, lc_d, E_OK);
					batch.n = batch.n + 2'd1;
				end
			end
		end

		if (take && last) begin
			mode_d = M_IDLE;
			acc_d  = '0;
			lcnt_d = '0;
			lc_d   = 16'd1;
			tl_d   = 16'd1;
			halt_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			acc_q  <= '0;
			lcnt_q <= '0;
			lc_q   <= 16'd1;
			tl_q   <= 16'd1;
			halt_q <= 1'b0;
		end else begin
			mode_q <= mode_d;
			acc_q  <= acc_d;
			lcnt_q <= lcnt_d;
			lc_q   <= lc_d;
			tl_q   <= tl_d;
			halt_q <= halt_d;
		end
	end

endmodule

/* hw/rtl/cll_queue.sv */
// Result queue: takes up to three results per cycle, hands out one per transfer.
`timescale 1ns / 1ps

module cll_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  cll_pkg::batch_t batch,
	output logic            room,
	output logic            out_valid,
	input  logic            out_ready,
	output cll_pkg::res_t   head
);
	import cll_pkg::*;

	res_t        ent_q [QDEPTH];
	res_t        ent_d [QDEPTH];
	logic [2:0]  cnt_q, cnt_d;
	logic        pop;
	logic [2:0]  base;
	logic [2:0]  k;

	assign out_valid = (cnt_q != 3'd0);
	assign pop       = out_valid && out_ready;
	assign room      = (cnt_q <= 3'd1);
	assign head      = ent_q[0];
	assign base      = cnt_q - {2'd0, pop};
	assign cnt_d     = base + {1'b0, batch.n};

	always_comb begin
		k = '0;
		for (int i = 0; i < QDEPTH; i++) begin
			ent_d[i] = ent_q[i];
		end
		if (pop) begin
			for (int i = 0; i < QDEPTH - 1; i++) begin
				ent_d[i] = ent_q[i + 1];
			end
		end
		for (int i = 0; i < QDEPTH; i++) begin
			k = 3'(i) - base;
			if (3'(i) >= base && k < {1'b0, batch.n}) ent_d[i] = batch.r[k[1:0]];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < QDEPTH; i++) begin
			ent_q[i] <= ent_d[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_d;
		end
	end

endmodule

/* hw/rtl/config_text_lexer.sv */
// Top level of the configuration text lexer: byte stream in, token stream out.
// Each result is registered in the result queue before it is offered on the output.
// Throughput: one byte per cycle while at most one result waits (a byte gives up to three
// results); the four-entry result queue drains one per cycle while m_axis_tready is high.
// Reset: asynchronous, clears lexer state (line one, idle) and empties the queue.
`timescale 1ns / 1ps

module config_text_lexer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] byte_in
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata,  // [31:0] token_value, [47:32] line_no, [50:48] error_code
	output logic [4:0]  m_axis_tuser,  // [3:0] token_kind, [4] char_valid
	output logic        m_axis_tlast
);
	import cll_pkg::*;

	batch_t batch;
	res_t   head;
	logic   take;

	assign take = s_axis_tvalid && s_axis_tready;

	cll_lexer u_lexer (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.c      (s_axis_tdata),
		.last   (s_axis_tlast),
		.batch  (batch)
	);

	cll_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.batch     (batch),
		.room      (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.head      (head)
	);

	assign m_axis_tdata = {5'd0, head.err, head.line_no, head.value};
	assign m_axis_tuser = {head.char_valid, head.kind};
	assign m_axis_tlast = head.token_end;

endmodule
